/* src/hgcd_pkg.sv */
// Shared constants, types and a helper function for the great-circle distance pipeline.
package hgcd_pkg;

  localparam int CORDIC_STAGES = 28;
  localparam int CIDX_W = $clog2(CORDIC_STAGES);
  localparam int CW = 34;
  localparam int SQ_W = 62;
  localparam int SQ_TOP = 60;
  localparam int SQ_STEPS = 31;
  localparam int SIDX_W = 5;
  localparam int RAD_W = 24;
  localparam int DIST_W = 34;
  localparam int LAT = 2 * CORDIC_STAGES + 69;

  localparam logic [RAD_W-1:0] RAD_RESET = 24'd6371000;
  localparam logic signed [34:0] Q30_ONE = 35'sd1073741824;
  localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q30 = 35'sd6746518852;
  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;

  typedef enum logic {
    CM_ROTATE,
    CM_VECTOR
  } cmode_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flag;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] res;
    logic [30:0]     tag;
  } sqrt_t;

  function automatic logic signed [CW-1:0] atan_entry(input logic [CIDX_W-1:0] i);
    int ii;
    logic signed [CW-1:0] r;
    ii = int'(i);
    r = '0;
    if (ii == 0) r = 34'sd843314856;
    else if (ii == 1) r = 34'sd497837829;
    else if (ii == 2) r = 34'sd263043836;
    else if (ii == 3) r = 34'sd133525158;
    else if (ii == 4) r = 34'sd67021686;
    else if (ii == 5) r = 34'sd33543515;
    else if (ii == 6) r = 34'sd16775850;
    else if (ii == 7) r = 34'sd8388437;
    else if (ii == 8) r = 34'sd4194282;
    else if (ii == 9) r = 34'sd2097149;
    else if (ii < 30) r = CW'((64'sd1 <<< (30 - ii)) - 64'sd1);
    return r;
  endfunction

endpackage

/* src/hgcd_in_if.sv */
// Input channel: two points as latitude and longitude.
interface hgcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lat_a;
  logic signed [31:0] lon_a;
  logic signed [31:0] lat_b;
  logic signed [31:0] lon_b;

  modport source (output valid, output lat_a, output lon_a, output lat_b, output lon_b,
                  input ready);
  modport sink (input valid, input lat_a, input lon_a, input lat_b, input lon_b,
                output ready);
endinterface

/* src/hgcd_out_if.sv */
// Output channel: distance in meters with 8 fraction bits.
interface hgcd_out_if;
  logic        valid;
  logic        ready;
  logic [33:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

/* src/hgcd_cordic_cell.sv */
// One CORDIC iteration cell, rotation or vectoring mode, registered.
module hgcd_cordic_cell import hgcd_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  cmode_t            mode,
  input  logic [CIDX_W-1:0] idx,
  input  cordic_t           d_in,
  output cordic_t           d_out
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] ang;
  logic                 dir;
  cordic_t              d_next;

  always_comb begin
    dx = d_in.y >>> idx;
    dy = d_in.x >>> idx;
    ang = atan_entry(idx);
    dir = (mode == CM_ROTATE) ? ~d_in.z[CW-1] : d_in.y[CW-1];
    d_next.flag = d_in.flag;
    if (dir) begin
      d_next.x = d_in.x - dx;
      d_next.y = d_in.y + dy;
      d_next.z = d_in.z - ang;
    end else begin
      d_next.x = d_in.x + dx;
      d_next.y = d_in.y - dy;
      d_next.z = d_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

/* src/hgcd_sqrt_cell.sv */
// One bit step of the integer square root, registered.
module hgcd_sqrt_cell import hgcd_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SIDX_W-1:0] idx,
  input  sqrt_t             d_in,
  output sqrt_t             d_out
);

  logic [5:0]      sh;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;
  sqrt_t           d_next;

  always_comb begin
    sh = 6'(SQ_TOP) - {idx, 1'b0};
    bitv = SQ_W'(1) << sh;
    trial = d_in.res + bitv;
    d_next.tag = d_in.tag;
    if (d_in.v >= trial) begin
      d_next.v = d_in.v - trial;
      d_next.res = (d_in.res >> 1) + bitv;
    end else begin
      d_next.v = d_in.v;
      d_next.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

/* src/haversine_great_circle_distance.sv */
// Haversine great-circle distance engine: top level pipeline.
// Fully pipelined: one transaction per cycle. The pipeline consists of four parallel
// rotation CORDIC rows, two 31-step square-root rows, one vectoring CORDIC row and
// seven input/multiply/format registers. The whole pipeline holds while a result waits
// at the output.
module haversine_great_circle_distance import hgcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [RAD_W-1:0] cfg_wr_data,
  hgcd_in_if.sink          in_ch,
  hgcd_out_if.source       out_ch
);

  localparam int N = CORDIC_STAGES;

  function automatic logic signed [34:0] wrap_angle(input logic signed [34:0] a);
    logic signed [34:0] r;
    r = a;
    if (a > PI_Q30) r = a - TWO_PI_Q30;
    else if (a < -PI_Q30) r = a + TWO_PI_Q30;
    return r;
  endfunction

  function automatic cordic_t hav_start(input logic signed [34:0] a);
    cordic_t r;
    logic signed [34:0] w;
    w = wrap_angle(a);
    r.x = CORDIC_START;
    r.y = '0;
    r.z = CW'(w >>> 1);
    r.flag = 1'b0;
    return r;
  endfunction

  function automatic cordic_t cos_start(input logic signed [34:0] a);
    cordic_t r;
    logic signed [34:0] w;
    w = wrap_angle(a);
    if (w < 0) w = -w;
    r.flag = 1'b0;
    if (w > HALF_PI_Q30) begin
      w = PI_Q30 - w;
      r.flag = 1'b1;
    end
    r.x = CORDIC_START;
    r.y = '0;
    r.z = CW'(w);
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v > CW'(Q30_ONE)) r = 32'(Q30_ONE);
    else if (v < -CW'(Q30_ONE)) r = -32'(Q30_ONE);
    else r = 32'(v);
    return r;
  endfunction

  logic             en;
  logic [LAT-1:0]   vld;
  logic [RAD_W-1:0] radius;

  cordic_t rot [4][N+1];
  cordic_t vec [N+1];
  sqrt_t   sq1 [SQ_STEPS+1];
  sqrt_t   sq2 [SQ_STEPS+1];

  logic signed [34:0] la, lo_a, lb, lo_b;
  logic signed [31:0] s_lat, s_lon, c_a, c_b;
  logic signed [63:0] prod_cc, sq_lat, sq_lon, p2;
  logic signed [31:0] cc_w;
  logic [30:0]        hlon, hlat_r, h_r;
  logic signed [34:0] h_sum;
  logic [30:0]        q_r;
  logic [SQ_W-1:0]    qq_r;
  logic [30:0]        ang;
  logic [55:0]        prod_d;
  logic [DIST_W-1:0]  dist_r;

  assign en = out_ch.ready | ~vld[LAT-1];
  assign in_ch.ready = en;
  assign out_ch.valid = vld[LAT-1];
  assign out_ch.distance = dist_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RAD_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  always_comb begin
    la   = {{2{in_ch.lat_a[31]}}, in_ch.lat_a, 1'b0};
    lo_a = {{2{in_ch.lon_a[31]}}, in_ch.lon_a, 1'b0};
    lb   = {{2{in_ch.lat_b[31]}}, in_ch.lat_b, 1'b0};
    lo_b = {{2{in_ch.lon_b[31]}}, in_ch.lon_b, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot[0][0] <= hav_start(lb - la);
      rot[1][0] <= hav_start(lo_b - lo_a);
      rot[2][0] <= cos_start(la);
      rot[3][0] <= cos_start(lb);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_rot
    for (genvar i = 0; i < N; i++) begin : g_cell
      hgcd_cordic_cell u_cell (
        .clk   (clk),
        .en    (en),
        .mode  (CM_ROTATE),
        .idx   (CIDX_W'(i)),
        .d_in  (rot[k][i]),
        .d_out (rot[k][i+1])
      );
    end
  end

  always_comb begin
    s_lat = clamp_unit(rot[0][N].y);
    s_lon = clamp_unit(rot[1][N].y);
    c_a = rot[2][N].flag ? -clamp_unit(rot[2][N].x) : clamp_unit(rot[2][N].x);
    c_b = rot[3][N].flag ? -clamp_unit(rot[3][N].x) : clamp_unit(rot[3][N].x);
    cc_w = 32'(prod_cc >>> 30);
    hlon = 31'(sq_lon >> 30);
    h_sum = $signed({4'b0000, hlat_r}) + 35'(p2 >>> 30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_cc <= c_a * c_b;
      sq_lat <= s_lat * s_lat;
      sq_lon <= s_lon * s_lon;
      p2 <= cc_w * $signed({1'b0, hlon});
      hlat_r <= 31'(sq_lat >> 30);
      if (h_sum < 0) h_r <= '0;
      else if (h_sum > Q30_ONE) h_r <= 31'(Q30_ONE);
      else h_r <= 31'(h_sum);
    end
  end

  assign sq1[0] = '{v: SQ_W'(h_r) << 30, res: '0, tag: '0};

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq1
    hgcd_sqrt_cell u_cell (
      .clk   (clk),
      .en    (en),
      .idx   (SIDX_W'(i)),
      .d_in  (sq1[i]),
      .d_out (sq1[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= sq1[SQ_STEPS].res[30:0];
      qq_r <= SQ_W'(sq1[SQ_STEPS].res[30:0]) * SQ_W'(sq1[SQ_STEPS].res[30:0]);
    end
  end

  assign sq2[0] = '{v: (SQ_W'(1) << SQ_TOP) - qq_r, res: '0, tag: q_r};

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq2
    hgcd_sqrt_cell u_cell (
      .clk   (clk),
      .en    (en),
      .idx   (SIDX_W'(i)),
      .d_in  (sq2[i]),
      .d_out (sq2[i+1])
    );
  end

  assign vec[0] = '{x: CW'(sq2[SQ_STEPS].res), y: CW'(sq2[SQ_STEPS].tag), z: '0,
                    flag: 1'b0};

  for (genvar i = 0; i < N; i++) begin : g_vec
    hgcd_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .mode  (CM_VECTOR),
      .idx   (CIDX_W'(i)),
      .d_in  (vec[i]),
      .d_out (vec[i+1])
    );
  end

  assign ang = vec[N].z[CW-1] ? '0 : vec[N].z[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_d <= 56'({radius, 1'b0}) * 56'(ang);
      dist_r <= DIST_W'((57'(prod_d) + 57'(1 << 21)) >> 22);
    end
  end

`ifndef SYNTHESIS
  a_h_range: assert property (@(posedge clk) disable iff (rst)
    vld[N+3] |-> (h_r <= 31'(Q30_ONE)))
    else $error("haversine sum out of range");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    vld[N+34] |-> (sq1[SQ_STEPS].res <= SQ_W'(Q30_ONE)))
    else $error("square root exceeds one");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> (vld == $past(vld)))
    else $error("pipeline moved during stall");
`endif

endmodule
